// ===== design/fpa_pkg.sv =====
// Package for the Q24.8 fixed-point ALU: widths, opcodes, status codes.
// No dependencies.
`default_nettype none
package fpa_pkg;
  localparam int DataWidth = 32;
  localparam int FracBits  = 8;
  localparam int QuoWidth  = DataWidth + FracBits;
  localparam int NumCells  = QuoWidth;

  typedef logic [DataWidth-1:0] data_t;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_LT = 4'd4, OP_GT = 4'd5, OP_LE = 4'd6, OP_GE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_INC = 4'd10, OP_MAX = 4'd11,
    OP_MIN = 4'd12, OP_I2F = 4'd13, OP_F2I = 4'd14, OP_NONE = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_OVF = 2'd1, ST_DIVZ = 2'd2, ST_RSVD = 2'd3
  } status_t;

  // Payload carried down the cell row.
  typedef struct packed {
    logic                 vld;
    logic                 divide;
    logic                 neg;
    logic                 divz;
    logic [DataWidth-1:0] rmd;
    logic [DataWidth-1:0] dvs;
    logic [QuoWidth-1:0]  num;
    logic [DataWidth-1:0] res;
    logic                 cond;
    logic [1:0]           status;
  } cell_t;

  localparam data_t WMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam data_t WMin = {1'b1, {(DataWidth-1){1'b0}}};
endpackage
`default_nettype wire

// ===== design/fpa_if.sv =====
// Valid/ready channel interfaces for the fixed-point ALU.
// Depends on fpa_pkg.
`default_nettype none
interface fpa_in_if import fpa_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic signed [DataWidth-1:0] a_raw;
  logic signed [DataWidth-1:0] b_raw;
  modport source (output valid, op, a_raw, b_raw, input ready);
  modport sink (input valid, op, a_raw, b_raw, output ready);
endinterface

interface fpa_out_if import fpa_pkg::*; ();
  logic        valid;
  logic        ready;
  logic signed [DataWidth-1:0] result_raw;
  logic        cond;
  logic [1:0]  status;
  modport source (output valid, result_raw, cond, status, input ready);
  modport sink (input valid, result_raw, cond, status, output ready);
endinterface
`default_nettype wire

// ===== design/fpa_front.sv =====
// Front stage: decodes op, does all non-divide ops including multiply,
// and sets up the division for the cell row. Depends on fpa_pkg.
`default_nettype none
module fpa_front import fpa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_vld,
  input  wire logic [3:0]  op,
  input  wire data_t       a,
  input  wire data_t       b,
  output cell_t            q_r
);
  logic sa, sb, lt_ab, lt_ba;
  data_t ma, mb, sum, dif, r;
  logic [2*DataWidth-1:0] prod_r;
  logic mul_r, mneg_r;
  logic [2*DataWidth-1:0] pr;
  logic [2*DataWidth-FracBits-1:0] sh;
  logic [DataWidth+FracBits:0] i2f;
  cell_t c, q_nxt;
  cell_t q_pre_r;

  assign sa = a[DataWidth-1];
  assign sb = b[DataWidth-1];
  assign ma = sa ? (~a + 1'b1) : a;
  assign mb = sb ? (~b + 1'b1) : b;
  assign lt_ab = $signed(a) < $signed(b);
  assign lt_ba = $signed(b) < $signed(a);
  assign sum = a + b;
  assign dif = a - b;
  assign i2f = {1'b0, ma, {FracBits{1'b0}}};

  always_comb begin
    c = '0;
    c.vld = in_vld;
    c.dvs = mb;
    c.num = {ma, {FracBits{1'b0}}};
    c.neg = sa ^ sb;
    r = '0;
    unique case (op_t'(op))
      OP_ADD: begin
        c.res = sum;
        if (sa == sb && sum[DataWidth-1] != sa) begin
          c.status = ST_OVF; c.res = sa ? WMin : WMax;
        end
      end
      OP_SUB: begin
        c.res = dif;
        if (sa != sb && dif[DataWidth-1] != sa) begin
          c.status = ST_OVF; c.res = sa ? WMin : WMax;
        end
      end
      OP_MUL: c.res = '0;
      OP_DIV: begin
        if (b == '0) begin
          c.divz = 1'b1; c.status = ST_DIVZ;
          c.res = (a == '0) ? '0 : (sa ? WMin : WMax);
        end else begin
          c.divide = 1'b1;
        end
      end
      OP_LT: c.cond = lt_ab;
      OP_GT: c.cond = lt_ba;
      OP_LE: c.cond = !lt_ba;
      OP_GE: c.cond = !lt_ab;
      OP_EQ: c.cond = (a == b);
      OP_NE: c.cond = (a != b);
      OP_INC: begin
        if (a == WMax) begin c.status = ST_OVF; c.res = WMax; end
        else c.res = a + 1'b1;
      end
      OP_MAX: c.res = lt_ba ? a : b;
      OP_MIN: c.res = lt_ab ? a : b;
      OP_I2F: begin
        if (!sa && i2f > {1'b0, {FracBits{1'b0}}, WMax}) begin
          c.status = ST_OVF; c.res = WMax;
        end else if (sa && i2f > {1'b0, {FracBits{1'b0}}, WMin}) begin
          c.status = ST_OVF; c.res = WMin;
        end else begin
          r = i2f[DataWidth-1:0];
          c.res = sa ? (~r + 1'b1) : r;
        end
      end
      OP_F2I: begin
        r = ma >> FracBits;
        c.res = sa ? (~r + 1'b1) : r;
      end
      default: c = c;
    endcase
    // Finish the registered multiply.
    pr = prod_r + (2*DataWidth)'(1 << (FracBits-1));
    sh = pr[2*DataWidth-1:FracBits];
    q_nxt = q_pre_r;
    if (mul_r) begin
      if (!mneg_r && sh > (2*DataWidth-FracBits)'(WMax)) begin
        q_nxt.status = ST_OVF; q_nxt.res = WMax;
      end else if (mneg_r && sh > (2*DataWidth-FracBits)'(WMin)) begin
        q_nxt.status = ST_OVF; q_nxt.res = WMin;
      end else begin
        q_nxt.res = mneg_r ? (~sh[DataWidth-1:0] + 1'b1) : sh[DataWidth-1:0];
      end
    end
  end

  // Two-stage front: stage one multiplies, stage two rounds and saturates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_pre_r.vld <= 1'b0;
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_pre_r <= c;
      prod_r <= ma * mb;
      mul_r <= in_vld && (op_t'(op) == OP_MUL);
      mneg_r <= sa ^ sb;
      q_r <= q_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== design/fpa_cell.sv =====
// One restoring-division cell: one quotient bit per cell, registered.
// Non-divide items pass through untouched. Depends on fpa_pkg.
`default_nettype none
module fpa_cell import fpa_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire cell_t d,
  output cell_t      q_r
);
  logic [DataWidth:0] tr;
  logic ge;
  cell_t q_nxt;

  always_comb begin
    q_nxt = d;
    tr = {d.rmd, d.num[QuoWidth-1]};
    ge = tr >= {1'b0, d.dvs};
    if (d.divide) begin
      q_nxt.rmd = ge ? DataWidth'(tr - {1'b0, d.dvs}) : tr[DataWidth-1:0];
      q_nxt.num = {d.num[QuoWidth-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) q_r.vld <= 1'b0;
    else if (en) q_r <= q_nxt;
  end
endmodule
`default_nettype wire

// ===== design/fixed_point_alu.sv =====
// Top level of the Q24.8 fixed-point ALU: front stage, division cell row,
// rounding stage and output register. Depends on fpa_pkg, fpa_if, fpa_front, fpa_cell.
`default_nettype none
// One item per cycle while the output is not stalled: items
// travel in order through a two-stage front (the non-divide ops and a
// registered 32x32 multiply), a row of 40 division cells that each retire
// one quotient bit, and a rounding/saturation stage. The whole pipe
// advances when the output register is empty or being taken.
module fixed_point_alu import fpa_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fpa_in_if.sink     in_ch,
  fpa_out_if.source  out_ch
);
  logic en;
  cell_t row [NumCells+1];
  logic [QuoWidth:0] qr;
  logic rnd;
  logic ovf;
  data_t res_nxt;
  logic [1:0] st_nxt;
  logic vld_r;
  data_t res_r;
  logic cond_r;
  logic [1:0] st_r;
  cell_t t;

  assign en = !vld_r || out_ch.ready;
  assign in_ch.ready = en;

  fpa_front u_front (
    .clk, .rst_n, .en, .in_vld(in_ch.valid), .op(in_ch.op),
    .a(data_t'(in_ch.a_raw)), .b(data_t'(in_ch.b_raw)), .q_r(row[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    fpa_cell u_cell (.clk, .rst_n, .en, .d(row[i]), .q_r(row[i+1]));
  end

  always_comb begin
    t = row[NumCells];
    // Round half away from zero: remainder >= divisor - remainder.
    rnd = {1'b0, t.rmd} >= ({1'b0, t.dvs} - {1'b0, t.rmd});
    qr = {1'b0, t.num} + (QuoWidth+1)'(rnd);
    res_nxt = t.res;
    st_nxt = t.status;
    ovf = 1'b0;
    if (t.divide) begin
      if (!t.neg) begin
        ovf = qr > (QuoWidth+1)'(WMax);
        res_nxt = ovf ? WMax : qr[DataWidth-1:0];
      end else begin
        ovf = qr > (QuoWidth+1)'(WMin);
        res_nxt = ovf ? WMin : (~qr[DataWidth-1:0] + 1'b1);
      end
      st_nxt = ovf ? ST_OVF : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= t.vld;
      res_r <= res_nxt;
      cond_r <= t.cond;
      st_r <= st_nxt;
    end
  end

  assign out_ch.valid = vld_r;
  assign out_ch.result_raw = res_r;
  assign out_ch.cond = cond_r;
  assign out_ch.status = st_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(res_r) && vld_r)
    else $error("output changed under stall");
  a_cond_no_res: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && cond_r |-> res_r == '0 && st_r == ST_OK)
    else $error("comparison carried a value");
  a_divz_code: assert property (@(posedge clk) disable iff (!rst_n)
    en && t.vld && t.divz |=> st_r == ST_DIVZ)
    else $error("divide by zero status lost");
endmodule
`default_nettype wire
